// ===== rtl/core/sic_pkg.sv =====
// Shared constants and types for the string isomorphism checker.
package sic_pkg;

    // Default character width in bits.
    localparam int CHAR_BITS_DEFAULT = 8;

    // Session tags stored beside each map entry; the all-zero tag means "never valid".
    localparam int                    EPOCH_BITS  = 8;
    localparam logic [EPOCH_BITS-1:0] EPOCH_NONE  = '0;
    localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
    localparam logic [EPOCH_BITS-1:0] EPOCH_MAX   = '1;

    // Control states of the checker.
    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } state_t;

endpackage

// ===== rtl/core/string_isomorphism_checker.sv =====
// Top level: streaming isomorphism check of two strings given as character pairs.
// Throughput: one character pair per cycle while s_ready is high, set by the map
// read-modify-write loop, which closes through a one-deep write forwarding path in each
// map memory. The result passes through the check stage register and the output buffer
// to the m_ ports. Reset: a clearing pass writes the null tag to every map entry; the
// same pass runs again after every 255 strings when the session tag wraps.
module string_isomorphism_checker #(
    parameter int CHAR_BITS = sic_pkg::CHAR_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CHAR_BITS-1:0] s_char_a,
    input  logic [CHAR_BITS-1:0] s_char_b,
    input  logic                 s_last,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_is_isomorphic
);

    localparam int EB = sic_pkg::EPOCH_BITS;
    localparam int WB = EB + CHAR_BITS;

    sic_pkg::state_t state_reg, state_next;
    logic [EB-1:0]        epoch_reg, epoch_next;
    logic [CHAR_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic                 mismatch_reg, mismatch_next;

    // Check stage registers.
    logic                 p1_valid_reg, p1_valid_next;
    logic [CHAR_BITS-1:0] p1_a_reg, p1_b_reg;
    logic                 p1_last_reg;

    // Forwarding of the write made at the edge an item's read was issued.
    logic          fwd_f_hit_reg, fwd_r_hit_reg;
    logic [WB-1:0] fwd_f_data_reg, fwd_r_data_reg;

    logic                 s_accept;
    logic                 p1_fire;
    logic                 wrap_block;
    logic                 out_full;
    logic [WB-1:0]        f_rd_data, r_rd_data, f_word, r_word;
    logic                 f_hit, r_hit, bad, mismatch_total;
    logic                 f_wr_en, r_wr_en;
    logic [CHAR_BITS-1:0] f_wr_addr, r_wr_addr;
    logic [WB-1:0]        f_wr_data, r_wr_data;
    logic                 res_valid, res_data;

    // Handshake on the input side.
    assign wrap_block = p1_valid_reg && p1_last_reg && (epoch_reg == sic_pkg::EPOCH_MAX);
    assign s_ready    = (state_reg == sic_pkg::ST_RUN) && !out_full && !wrap_block;
    assign s_accept   = s_valid && s_ready;

    // Map memories: forward indexed by the first character, reverse by the second.
    sic_map_ram #(
        .ADDR_BITS(CHAR_BITS),
        .DATA_BITS(WB)
    ) u_fwd_ram (
        .aclk   (aclk),
        .wr_en  (f_wr_en),
        .wr_addr(f_wr_addr),
        .wr_data(f_wr_data),
        .rd_en  (s_accept),
        .rd_addr(s_char_a),
        .rd_data(f_rd_data)
    );

    sic_map_ram #(
        .ADDR_BITS(CHAR_BITS),
        .DATA_BITS(WB)
    ) u_rev_ram (
        .aclk   (aclk),
        .wr_en  (r_wr_en),
        .wr_addr(r_wr_addr),
        .wr_data(r_wr_data),
        .rd_en  (s_accept),
        .rd_addr(s_char_b),
        .rd_data(r_rd_data)
    );

    // Entry lookup with forwarding; an entry counts only when its tag is the current session.
    always_comb begin
        f_word         = fwd_f_hit_reg ? fwd_f_data_reg : f_rd_data;
        r_word         = fwd_r_hit_reg ? fwd_r_data_reg : r_rd_data;
        f_hit          = (f_word[WB-1:CHAR_BITS] == epoch_reg);
        r_hit          = (r_word[WB-1:CHAR_BITS] == epoch_reg);
        bad            = (f_hit && (f_word[CHAR_BITS-1:0] != p1_b_reg)) ||
                         (r_hit && (r_word[CHAR_BITS-1:0] != p1_a_reg));
        mismatch_total = mismatch_reg || bad;
        p1_fire        = p1_valid_reg && !(p1_last_reg && out_full);
        res_valid      = p1_fire && p1_last_reg;
        res_data       = !mismatch_total;
    end

    // Map writes: new mappings while running, null tags during the clearing pass.
    always_comb begin
        if (state_reg == sic_pkg::ST_CLEAR) begin
            f_wr_en   = 1'b1;
            r_wr_en   = 1'b1;
            f_wr_addr = clr_cnt_reg;
            r_wr_addr = clr_cnt_reg;
            f_wr_data = {sic_pkg::EPOCH_NONE, {CHAR_BITS{1'b0}}};
            r_wr_data = {sic_pkg::EPOCH_NONE, {CHAR_BITS{1'b0}}};
        end else begin
            f_wr_en   = p1_fire && !bad && !f_hit;
            r_wr_en   = p1_fire && !bad && !r_hit;
            f_wr_addr = p1_a_reg;
            r_wr_addr = p1_b_reg;
            f_wr_data = {epoch_reg, p1_b_reg};
            r_wr_data = {epoch_reg, p1_a_reg};
        end
    end

    // Session control: mismatch flag, session tag and the clearing pass.
    always_comb begin
        state_next    = state_reg;
        epoch_next    = epoch_reg;
        clr_cnt_next  = clr_cnt_reg;
        mismatch_next = mismatch_reg;
        p1_valid_next = p1_valid_reg;
        unique case (state_reg)
            sic_pkg::ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + CHAR_BITS'(1);
                if (clr_cnt_reg == {CHAR_BITS{1'b1}}) begin
                    state_next = sic_pkg::ST_RUN;
                    epoch_next = sic_pkg::EPOCH_FIRST;
                end
            end
            sic_pkg::ST_RUN: begin
                if (p1_fire) begin
                    p1_valid_next = 1'b0;
                    if (p1_last_reg) begin
                        mismatch_next = 1'b0;
                        if (epoch_reg == sic_pkg::EPOCH_MAX) begin
                            state_next   = sic_pkg::ST_CLEAR;
                            clr_cnt_next = '0;
                        end else begin
                            epoch_next = epoch_reg + EB'(1);
                        end
                    end else begin
                        mismatch_next = mismatch_total;
                    end
                end
                if (s_accept) begin
                    p1_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = sic_pkg::ST_CLEAR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sic_pkg::ST_CLEAR;
            epoch_reg    <= sic_pkg::EPOCH_FIRST;
            clr_cnt_reg  <= '0;
            mismatch_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            epoch_reg    <= epoch_next;
            clr_cnt_reg  <= clr_cnt_next;
            mismatch_reg <= mismatch_next;
            p1_valid_reg <= p1_valid_next;
        end
    end

    // Item capture and forwarding registers, loaded as the item is accepted.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_a_reg       <= s_char_a;
            p1_b_reg       <= s_char_b;
            p1_last_reg    <= s_last;
            fwd_f_hit_reg  <= f_wr_en && (f_wr_addr == s_char_a);
            fwd_r_hit_reg  <= r_wr_en && (r_wr_addr == s_char_b);
            fwd_f_data_reg <= f_wr_data;
            fwd_r_data_reg <= r_wr_data;
        end
    end

    // Result buffer.
    sic_out_buf u_out_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(res_valid),
        .in_data (res_data),
        .full    (out_full),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_is_isomorphic)
    );

    // A finished string always reaches the output register or the skid stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> m_valid)
        else $error("result of a last pair was lost");

    // The session tag steps by one on every ordinary string end.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_fire && p1_last_reg && (epoch_reg != sic_pkg::EPOCH_MAX))
        |=> (epoch_reg == $past(epoch_reg) + EB'(1)))
        else $error("session tag did not advance");

    // A wrapping session tag starts the clearing pass, and no item enters meanwhile.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_fire && p1_last_reg && (epoch_reg == sic_pkg::EPOCH_MAX))
        |=> ((state_reg == sic_pkg::ST_CLEAR) && !p1_valid_reg))
        else $error("tag wrap did not start a clearing pass");

    // A same-edge write to the entry being read must be forwarded.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && f_wr_en && (f_wr_addr == s_char_a)) |=> fwd_f_hit_reg)
        else $error("forward map write not forwarded");

    // The result buffer never receives an item while its skid stage is occupied.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !out_full)
        else $error("result offered to a full output buffer");

endmodule

// ===== rtl/core/sic_map_ram.sv =====
// Single-port-write, single-port-read map memory with a registered read.
module sic_map_ram #(
    parameter int ADDR_BITS = sic_pkg::CHAR_BITS_DEFAULT,
    parameter int DATA_BITS = sic_pkg::CHAR_BITS_DEFAULT + sic_pkg::EPOCH_BITS
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    // Write port, and a read that returns the old contents on a same-edge collision.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/sic_out_buf.sv =====
// Output register with a skid stage for the result channel.
module sic_out_buf (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    input  logic in_data,
    output logic full,
    output logic m_valid,
    input  logic m_ready,
    output logic m_data
);

    logic m_valid_reg, m_valid_next;
    logic m_data_reg, m_data_next;
    logic skid_valid_reg, skid_valid_next;
    logic skid_data_reg, skid_data_next;

    // Control flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload holds need no reset.
    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    // The user must offer a new item only while the skid stage is empty; this block does not enforce it.
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_next    = 1'b1;
                m_data_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = in_valid;
                m_data_next  = in_data;
            end
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    assign full    = skid_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== tb/string_isomorphism_checker_tb.sv =====
// Self-checking testbench for the streaming string isomorphism checker.
`timescale 1ns / 100ps

module string_isomorphism_checker_tb;

    localparam int  CW          = sic_pkg::CHAR_BITS_DEFAULT;
    localparam int  NUM_CHARS   = 1 << CW;
    localparam int  RANDOM_PAIRS = 1550;
    localparam int  HOLD_CYCLES = 400;
    localparam int  DRAIN_CYCLES = 10;

    typedef logic [CW-1:0] char_t;

    // Predicts the verdict of each string from its character pairs and checks the results.
    class iso_scoreboard;
        char_t fwd_map [NUM_CHARS];
        bit    fwd_set [NUM_CHARS];
        char_t rev_map [NUM_CHARS];
        bit    rev_set [NUM_CHARS];
        bit    conflict_seen;
        bit    verdict_q [$];
        int    errors;

        // Prints one line per failed check and counts them all.
        task report(string msg);
            $display("[%0t] check failed: %s", $realtime, msg);
            errors++;
        endtask

        // Applies one accepted pair to the predicted maps; a last pair queues the verdict.
        function void note_pair(char_t a, char_t b, bit is_last);
            bit clash;
            clash = (fwd_set[a] && fwd_map[a] != b) || (rev_set[b] && rev_map[b] != a);
            if (clash) begin
                conflict_seen = 1'b1;
            end else begin
                if (!fwd_set[a]) begin
                    fwd_map[a] = b;
                    fwd_set[a] = 1'b1;
                end
                if (!rev_set[b]) begin
                    rev_map[b] = a;
                    rev_set[b] = 1'b1;
                end
            end
            if (is_last) begin
                verdict_q.push_back(!conflict_seen);
                for (int i = 0; i < NUM_CHARS; i++) begin
                    fwd_set[i] = 1'b0;
                    rev_set[i] = 1'b0;
                end
                conflict_seen = 1'b0;
            end
        endfunction

        // Compares one accepted result with the oldest predicted verdict.
        task check_result(logic iso);
            bit want;
            if (verdict_q.size() == 0) begin
                report($sformatf("result %b arrived with no string outstanding", iso));
            end else begin
                want = verdict_q.pop_front();
                if (iso !== want) begin
                    report($sformatf("is_isomorphic is %b, predicted %b", iso, want));
                end
            end
        endtask

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    char_t s_char_a;
    char_t s_char_b;
    logic  s_last;
    logic  m_valid;
    logic  m_ready;
    logic  m_is_isomorphic;

    iso_scoreboard verdicts;
    int pairs_sent;
    int send_run_left;
    int recv_run_left;
    bit hold_out_results;

    string_isomorphism_checker dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_a        (s_char_a),
        .s_char_b        (s_char_b),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_is_isomorphic (m_is_isomorphic)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Idle cycles before an item; runs of back-to-back items come in now and then.
    function automatic int draw_gap(ref int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            run_left = $urandom_range(20, 60);
        end
        return $urandom_range(0, 19);
    endfunction

    // Offers one character pair and waits until the block accepts it.
    task automatic send_pair(input char_t a, input char_t b, input bit is_last);
        int gap;
        gap = draw_gap(send_run_left);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_char_a <= a;
        s_char_b <= b;
        s_last   <= is_last;
        do @(posedge aclk); while (!s_ready);
        verdicts.note_pair(a, b, is_last);
        pairs_sent++;
    endtask

    // Builds one string pair: mostly isomorphic by construction, some broken, some noise.
    task automatic send_random_string();
        int    len;
        int    pick;
        int    kind;
        int    pool_size;
        int    idx;
        char_t pool [8];
        char_t image [NUM_CHARS];
        bit    has_image [NUM_CHARS];
        bit    taken [NUM_CHARS];
        char_t str_a [64];
        char_t str_b [64];
        char_t cand;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            len = $urandom_range(1, 3);
        end else if (pick < 95) begin
            len = $urandom_range(4, 16);
        end else begin
            len = $urandom_range(17, 40);
        end
        kind = $urandom_range(0, 99);
        pool_size = $urandom_range(1, 8);
        for (int i = 0; i < pool_size; i++) begin
            pool[i] = char_t'($urandom_range(0, NUM_CHARS - 1));
        end
        // Small alphabet with an injective image, so characters repeat consistently.
        for (int i = 0; i < len; i++) begin
            str_a[i] = pool[$urandom_range(0, pool_size - 1)];
            if (!has_image[str_a[i]]) begin
                do cand = char_t'($urandom_range(0, NUM_CHARS - 1)); while (taken[cand]);
                image[str_a[i]]     = cand;
                has_image[str_a[i]] = 1'b1;
                taken[cand]         = 1'b1;
            end
            str_b[i] = image[str_a[i]];
        end
        if (kind < 30) begin
            // Corrupt one position on either side.
            idx = $urandom_range(0, len - 1);
            if ($urandom_range(0, 1) == 1) begin
                str_b[idx] = pool[$urandom_range(0, pool_size - 1)];
            end else begin
                str_a[idx] = pool[$urandom_range(0, pool_size - 1)];
            end
        end else if (kind >= 85) begin
            // Unstructured pairs.
            for (int i = 0; i < len; i++) begin
                str_a[i] = char_t'($urandom_range(0, NUM_CHARS - 1));
                str_b[i] = char_t'($urandom_range(0, NUM_CHARS - 1));
            end
        end
        for (int i = 0; i < len; i++) begin
            send_pair(str_a[i], str_b[i], i == len - 1);
        end
    endtask

    // Withdraws the offer and holds the sender until every predicted verdict has been received.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (verdicts.pending() != 0);
    endtask

    // Stimulus and end of run.
    initial begin
        bit hold_done;
        bit drain_done;
        verdicts         = new;
        pairs_sent       = 0;
        send_run_left    = 0;
        recv_run_left    = 0;
        hold_out_results = 1'b0;
        hold_done        = 1'b0;
        drain_done       = 1'b0;
        aresetn  <= 1'b0;
        s_valid  <= 1'b0;
        s_char_a <= '0;
        s_char_b <= '0;
        s_last   <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Single-pair strings at the extremes of the character range.
        send_pair(8'h00, 8'h00, 1'b1);
        send_pair(8'hFF, 8'hFF, 1'b1);
        send_pair(8'h00, 8'hFF, 1'b1);
        send_pair(8'hFF, 8'h00, 1'b1);
        // Two first characters onto one second character: reverse map conflict.
        send_pair(8'h01, 8'h09, 1'b0);
        send_pair(8'h02, 8'h09, 1'b1);
        // One first character onto two second characters: forward map conflict.
        send_pair(8'h03, 8'h04, 1'b0);
        send_pair(8'h03, 8'h05, 1'b1);
        // Consistent pairs after a conflict leave the verdict false.
        send_pair(8'h0A, 8'h14, 1'b0);
        send_pair(8'h0A, 8'h15, 1'b0);
        send_pair(8'h0B, 8'h15, 1'b0);
        send_pair(8'h0C, 8'h16, 1'b1);
        // The maps of the previous string must have been cleared.
        send_pair(8'h0A, 8'h15, 1'b0);
        send_pair(8'h0B, 8'h14, 1'b1);
        // Swapped bit patterns with a repeat.
        send_pair(8'hAA, 8'h55, 1'b0);
        send_pair(8'h55, 8'hAA, 1'b0);
        send_pair(8'hAA, 8'h55, 1'b0);
        send_pair(8'h00, 8'hFF, 1'b1);
        send_pair(8'h80, 8'h01, 1'b0);
        send_pair(8'h7F, 8'hFE, 1'b0);
        send_pair(8'h80, 8'h01, 1'b1);
        wait_for_results();

        // Random strings, with one long receiver hold-off and one full drain.
        pairs_sent = 0;
        while (pairs_sent < RANDOM_PAIRS) begin
            if (!hold_done && pairs_sent >= 400) begin
                hold_out_results = 1'b1;
                send_run_left    = 200;
                hold_done        = 1'b1;
            end
            if (!drain_done && pairs_sent >= 1000) begin
                wait_for_results();
                drain_done = 1'b1;
            end
            send_random_string();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (verdicts.errors == 0 && verdicts.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Result side: random stalls, one long hold-off on request.
    initial begin
        int gap;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_out_results) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_out_results = 1'b0;
            end
            gap = draw_gap(recv_run_left);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            verdicts.check_result(m_is_isomorphic);
        end
    end

    // Run limit, well above the slowest correct run including clearing passes.
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
